[src/brsi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsi_pkg: shared types and constants of the banded row store
// Sizes, command and status codes, transaction payloads and sequencer states.
// ----------------------------------------------------------------------------
package brsi_pkg;

    // Store geometry
    localparam int ROWS       = 64;
    localparam int BAND_MAX   = 16;
    localparam int VALUE_BITS = 32;
    localparam int ROW_BITS   = $clog2(ROWS);
    localparam int SLOT_BITS  = $clog2(BAND_MAX);
    localparam int SCNT_BITS  = $clog2(BAND_MAX + 1);
    localparam int ADDR_BITS  = ROW_BITS + SLOT_BITS;

    // Field widths
    localparam int CMD_BITS  = 2;
    localparam int COL_BITS  = 16;
    localparam int STAT_BITS = 3;
    localparam int CC_BITS   = 17;

    // Configuration register limits
    localparam logic [CC_BITS-1:0]   CC_MAX       = 17'd65536;
    localparam logic [SCNT_BITS-1:0] BAND_MAX_CNT = SCNT_BITS'(BAND_MAX);

    // Saturation limits
    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // Commands
    localparam logic [CMD_BITS-1:0] CMD_PUT  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_ADD  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_READ = 2'd2;

    // Result status codes
    localparam logic [STAT_BITS-1:0] ST_STORED  = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_ZERO    = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_OUTSIDE = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_SHIFTED = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_READ    = 3'd4;

    // Configuration register indexes
    localparam logic CFG_COLUMN_COUNT = 1'b0;
    localparam logic CFG_BAND_SLOTS   = 1'b1;

    typedef struct packed {
        logic [CMD_BITS-1:0]          cmd;
        logic [ROW_BITS-1:0]          row;
        logic [COL_BITS-1:0]          column;
        logic signed [VALUE_BITS-1:0] value;
    } t_cmd_item;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] read_value;
        logic [STAT_BITS-1:0]         status;
    } t_res_item;

    typedef struct packed {
        logic               index;
        logic [CC_BITS-1:0] wdata;
    } t_cfg_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_READ_WAIT,
        S_ADD_WR,
        S_FILL,
        S_SHIFT,
        S_SHIFT_END,
        S_DONE
    } t_state;

endpackage

[src/brsi_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsi interfaces: valid/ready channels of the banded row store
// Command input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface brsi_cmd_if import brsi_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cmd_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface brsi_res_if import brsi_pkg::*; ();
    logic      valid;
    logic      ready;
    t_res_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface brsi_cfg_if import brsi_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/banded_row_store_insert_unit.sv]
`timescale 1ns / 1ps
// Steps: a read waits for its registered slot read; an add reads, then writes its
//   slot; a row shift walks the band slots down from the top; the first store into an
//   empty row zeroes all BAND_MAX slots (one slot memory port access per cycle).
// Throughput: one command at a time; the next is taken once the sequencer is idle.
// Reset: synchronous active low; clears control and row valid bits, sets config to its maximums.
//   Slot memory is not swept: slots of empty rows read as zero via valid bits.
// ----------------------------------------------------------------------------
// banded_row_store_insert_unit: banded matrix row store with insert/accumulate
// Each row holds its first column and a band of slots in a single-port-write
// slot memory; a small sequencer fills, shifts, accumulates and reads slots.
// ----------------------------------------------------------------------------
module banded_row_store_insert_unit
    import brsi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    brsi_cmd_if.sink   i_cmd_ch,
    brsi_res_if.source o_res_ch,
    brsi_cfg_if.sink   i_cfg_ch
);

    // Storage
    logic signed [VALUE_BITS-1:0] r_band_mem [2**ADDR_BITS];
    logic [COL_BITS-1:0]          r_first_mem [ROWS];
    logic signed [VALUE_BITS-1:0] r_mem_q;
    logic [COL_BITS-1:0]          r_first_q;
    logic [ROWS-1:0]              r_row_valid, n_row_valid;

    // Configuration
    logic [CC_BITS-1:0]   r_cc;
    logic [SCNT_BITS-1:0] r_bs;

    // Sequencer and working registers
    t_state                       r_state, n_state;
    logic [CMD_BITS-1:0]          r_cmd;
    logic [ROW_BITS-1:0]          r_row;
    logic [COL_BITS-1:0]          r_col;
    logic signed [VALUE_BITS-1:0] r_val;
    logic [SLOT_BITS-1:0]         r_loc, n_loc;
    logic [COL_BITS-1:0]          r_gap, n_gap;
    logic [SLOT_BITS-1:0]         r_k, n_k;
    logic                         r_wpend, n_wpend;
    logic [SLOT_BITS-1:0]         r_wk, n_wk;
    logic                         r_wzero, n_wzero;
    t_res_item                    r_res, n_res;
    logic                         r_out_valid, n_out_valid;
    t_res_item                    r_out, n_out;

    // Memory port controls
    logic                         w_we;
    logic [ADDR_BITS-1:0]         w_waddr, w_raddr;
    logic signed [VALUE_BITS-1:0] w_wdata;
    logic                         w_fwe;
    logic [COL_BITS-1:0]          w_fdata;

    // Decode helpers
    logic [SCNT_BITS-1:0]         w_slots;
    logic [COL_BITS-1:0]          w_empty_first, w_first;
    logic [COL_BITS:0]            w_diff;
    logic                         w_ge, w_in_band;
    logic signed [VALUE_BITS:0]   w_sum;
    logic signed [VALUE_BITS-1:0] w_sat;
    logic                         w_accept;

    assign w_accept       = i_cmd_ch.valid && i_cmd_ch.ready;
    assign i_cmd_ch.ready = (r_state == S_IDLE);
    assign i_cfg_ch.ready = 1'b1;
    assign o_res_ch.valid = r_out_valid;
    assign o_res_ch.data  = r_out;

    // Clamped configuration
    always_comb begin
        if (r_bs == '0) begin
            w_slots = SCNT_BITS'(1);
        end else if (r_bs > BAND_MAX_CNT) begin
            w_slots = BAND_MAX_CNT;
        end else begin
            w_slots = r_bs;
        end
        if (r_cc == '0) begin
            w_empty_first = '0;
        end else if (r_cc > CC_MAX) begin
            w_empty_first = {COL_BITS{1'b1}};
        end else begin
            w_empty_first = COL_BITS'(r_cc - CC_BITS'(1));
        end
    end

    // Row window position of the current command
    assign w_first   = r_row_valid[r_row] ? r_first_q : w_empty_first;
    assign w_diff    = {1'b0, r_col} - {1'b0, w_first};
    assign w_ge      = !w_diff[COL_BITS];
    assign w_in_band = w_ge && (w_diff[COL_BITS-1:0] < COL_BITS'(w_slots));

    // Saturating accumulate of stored slot and value
    assign w_sum = {r_mem_q[VALUE_BITS-1], r_mem_q} + {r_val[VALUE_BITS-1], r_val};
    always_comb begin
        if (w_sum > (VALUE_BITS+1)'(VAL_MAX)) begin
            w_sat = VAL_MAX;
        end else if (w_sum < (VALUE_BITS+1)'(VAL_MIN)) begin
            w_sat = VAL_MIN;
        end else begin
            w_sat = w_sum[VALUE_BITS-1:0];
        end
    end

    // Sequencer: next state, memory controls and working registers
    always_comb begin
        n_state     = r_state;
        n_row_valid = r_row_valid;
        n_loc       = r_loc;
        n_gap       = r_gap;
        n_k         = r_k;
        n_wpend     = r_wpend;
        n_wk        = r_wk;
        n_wzero     = r_wzero;
        n_res       = r_res;
        n_out_valid = r_out_valid && !o_res_ch.ready;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = {r_row, r_k};
        w_wdata     = '0;
        w_raddr     = {r_row, w_diff[SLOT_BITS-1:0]};
        w_fwe       = 1'b0;
        w_fdata     = r_col;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_res.read_value = '0;
                n_loc            = w_diff[SLOT_BITS-1:0];
                if (r_cmd != CMD_PUT && r_cmd != CMD_ADD) begin
                    n_res.status = ST_READ;
                    if (r_row_valid[r_row] && w_in_band) begin
                        n_state = S_READ_WAIT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (r_val == '0) begin
                    n_res.status = ST_ZERO;
                    n_state      = S_DONE;
                end else if (!w_ge) begin
                    // new first entry left of the window
                    n_res.status       = ST_SHIFTED;
                    n_row_valid[r_row] = 1'b1;
                    w_fwe              = 1'b1;
                    w_fdata            = r_col;
                    n_gap              = w_first - r_col;
                    n_loc              = '0;
                    n_wpend            = 1'b0;
                    if (r_row_valid[r_row]) begin
                        n_k     = SLOT_BITS'(w_slots - SCNT_BITS'(1));
                        n_state = S_SHIFT;
                    end else begin
                        n_k     = '0;
                        n_state = S_FILL;
                    end
                end else if (w_in_band) begin
                    n_res.status       = ST_STORED;
                    n_row_valid[r_row] = 1'b1;
                    w_fwe              = 1'b1;
                    w_fdata            = w_first;
                    if (!r_row_valid[r_row]) begin
                        n_k     = '0;
                        n_state = S_FILL;
                    end else if (r_cmd == CMD_PUT) begin
                        w_we    = 1'b1;
                        w_waddr = {r_row, w_diff[SLOT_BITS-1:0]};
                        w_wdata = r_val;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ADD_WR;
                    end
                end else begin
                    n_res.status = ST_OUTSIDE;
                    n_state      = S_DONE;
                end
            end

            S_READ_WAIT: begin
                n_res.read_value = r_mem_q;
                n_state          = S_DONE;
            end

            S_ADD_WR: begin
                w_we    = 1'b1;
                w_waddr = {r_row, r_loc};
                w_wdata = w_sat;
                n_state = S_DONE;
            end

            // first store into an empty row: zero every slot, place the value
            S_FILL: begin
                w_we    = 1'b1;
                w_waddr = {r_row, r_k};
                w_wdata = (r_k == r_loc) ? r_val : '0;
                if (r_k == SLOT_BITS'(BAND_MAX - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_k = r_k + SLOT_BITS'(1);
                end
            end

            // shift the window down from the top slot: read k-gap, write k
            S_SHIFT: begin
                w_raddr = {r_row, r_k - r_gap[SLOT_BITS-1:0]};
                n_wk    = r_k;
                n_wzero = (COL_BITS'(r_k) < r_gap);
                n_wpend = 1'b1;
                if (r_wpend) begin
                    w_we    = 1'b1;
                    w_waddr = {r_row, r_wk};
                    w_wdata = r_wzero ? '0 : r_mem_q;
                end
                if (r_k == '0) begin
                    n_state = S_SHIFT_END;
                end else begin
                    n_k = r_k - SLOT_BITS'(1);
                end
            end

            S_SHIFT_END: begin
                w_we    = 1'b1;
                w_waddr = {r_row, r_wk};
                w_wdata = r_val;
                n_wpend = 1'b0;
                n_state = S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || o_res_ch.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
            r_wpend     <= 1'b0;
            r_cc        <= CC_MAX;
            r_bs        <= BAND_MAX_CNT;
        end else begin
            r_state     <= n_state;
            r_row_valid <= n_row_valid;
            r_out_valid <= n_out_valid;
            r_wpend     <= n_wpend;
            if (i_cfg_ch.valid && i_cfg_ch.ready) begin
                case (i_cfg_ch.data.index)
                    CFG_COLUMN_COUNT: r_cc <= i_cfg_ch.data.wdata;
                    CFG_BAND_SLOTS:   r_bs <= i_cfg_ch.data.wdata[SCNT_BITS-1:0];
                    default:          r_cc <= r_cc;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd_ch.data.cmd;
            r_row <= i_cmd_ch.data.row;
            r_col <= i_cmd_ch.data.column;
            r_val <= i_cmd_ch.data.value;
        end
        r_loc   <= n_loc;
        r_gap   <= n_gap;
        r_k     <= n_k;
        r_wk    <= n_wk;
        r_wzero <= n_wzero;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // Slot memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_band_mem[w_waddr] <= w_wdata;
        end
        r_mem_q <= r_band_mem[w_raddr];
    end

    // First-column memory, read at the incoming row
    always_ff @(posedge i_clk) begin
        if (w_fwe) begin
            r_first_mem[r_row] <= w_fdata;
        end
        r_first_q <= r_first_mem[i_cmd_ch.data.row];
    end

    // Checks
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_DECODE)
        else $error("accepted command not decoded next cycle");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_DECODE || r_state == S_ADD_WR || r_state == S_FILL ||
                  r_state == S_SHIFT || r_state == S_SHIFT_END))
        else $error("slot memory written outside a store step");

    a_read_only_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.status == ST_READ || r_out.read_value == '0))
        else $error("nonzero value on a non-read result");

    a_shift_marks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT || r_state == S_FILL) |-> r_row_valid[r_row])
        else $error("row rewritten without valid bit set");

endmodule

[tb/tb_banded_row_store_insert_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_banded_row_store_insert_unit: self-checking bench for the banded row store
// Drives put, add and read commands with bursty timing against a stalling
// result sink, mirrors the row windows in a behavioral store and checks every
// result in order. Runs through several column count and band width settings.
// ----------------------------------------------------------------------------
module tb_banded_row_store_insert_unit;
    import brsi_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;   // decoded as a read
    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 40;

    logic i_clk;
    logic i_rst_n;

    brsi_cmd_if cmd_ch ();
    brsi_res_if res_ch ();
    brsi_cfg_if cfg_ch ();

    banded_row_store_insert_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (cmd_ch),
        .o_res_ch (res_ch),
        .i_cfg_ch (cfg_ch)
    );

    // Behavioral copy of the store and its registers
    logic signed [VALUE_BITS-1:0] band_mem [ROWS][BAND_MAX];
    logic [COL_BITS-1:0]          first_col [ROWS];
    bit                           row_used [ROWS];
    logic [CC_BITS-1:0]           column_count_reg;
    logic [4:0]                   band_slots_reg;

    t_res_item expected_results[$];
    int        mismatches;
    int        burst_left;
    int        cycle_count;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("banded_row_store_insert_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Band width in use, clamped to 1..BAND_MAX
    function automatic int unsigned band_width();
        if (band_slots_reg == 0)
            return 1;
        if (band_slots_reg > BAND_MAX)
            return BAND_MAX;
        return 32'(band_slots_reg);
    endfunction

    // First column of a row; an empty row starts at the clamped column count - 1
    function automatic int unsigned row_first(input logic [ROW_BITS-1:0] row);
        int unsigned c;
        if (row_used[row])
            return 32'(first_col[row]);
        c = 32'(column_count_reg);
        if (c < 1)
            c = 1;
        if (c > 65536)
            c = 65536;
        return c - 1;
    endfunction

    // Apply one command to the store copy and return the result it produces
    function automatic t_res_item store_apply(input t_cmd_item item);
        t_res_item                    res;
        int unsigned                  slots;
        int unsigned                  first;
        int unsigned                  col;
        int unsigned                  gap;
        int unsigned                  loc;
        int                           k;
        longint                       sum;
        logic signed [VALUE_BITS-1:0] old_band [BAND_MAX];

        slots = band_width();
        col   = 32'(item.column);
        first = row_first(item.row);
        res.read_value = '0;

        if (item.cmd != CMD_PUT && item.cmd != CMD_ADD) begin
            res.status = ST_READ;
            if (col >= first && col - first < slots)
                res.read_value = band_mem[item.row][col - first];
        end else if (item.value == 0) begin
            res.status = ST_ZERO;
        end else if (col < first) begin
            // new first entry: slide the window left, value lands in slot 0
            gap = first - col;
            for (k = 0; k < BAND_MAX; k++)
                old_band[k] = band_mem[item.row][k];
            for (k = 0; k < int'(slots); k++)
                band_mem[item.row][k] = (k < gap) ? '0 : old_band[k - gap];
            band_mem[item.row][0] = item.value;
            first_col[item.row]   = col;
            row_used[item.row]    = 1'b1;
            res.status = ST_SHIFTED;
        end else if (col - first < slots) begin
            loc = col - first;
            if (item.cmd == CMD_PUT) begin
                band_mem[item.row][loc] = item.value;
            end else begin
                sum = longint'(band_mem[item.row][loc]) + longint'(item.value);
                if (sum > longint'(VAL_MAX))
                    sum = longint'(VAL_MAX);
                if (sum < longint'(VAL_MIN))
                    sum = longint'(VAL_MIN);
                band_mem[item.row][loc] = sum[VALUE_BITS-1:0];
            end
            first_col[item.row] = first;
            row_used[item.row]  = 1'b1;
            res.status = ST_STORED;
        end else begin
            res.status = ST_OUTSIDE;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Command sender, result sink and checker
    // ------------------------------------------------------------------------

    function automatic t_cmd_item cmd_item(input logic [CMD_BITS-1:0] cmd,
                                           input int unsigned row,
                                           input int unsigned col,
                                           input logic signed [VALUE_BITS-1:0] value);
        t_cmd_item it;
        it.cmd    = cmd;
        it.row    = row[ROW_BITS-1:0];
        it.column = col[COL_BITS-1:0];
        it.value  = value;
        return it;
    endfunction

    // Send one command transaction; valid stays up inside a burst
    task automatic send_cmd(input t_cmd_item item);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= item;
        do @(posedge i_clk); while (!cmd_ch.ready);
        expected_results.push_back(store_apply(item));
        burst_left--;
        if (burst_left == 0)
            cmd_ch.valid <= 1'b0;
    endtask

    // Drop command valid; called in the step of the last accept
    task automatic hold_commands();
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
    endtask

    // Write both registers back to back once the store has gone idle
    task automatic configure(input logic [CC_BITS-1:0] cc_wdata,
                             input logic [CC_BITS-1:0] bs_wdata);
        t_cfg_item w;
        hold_commands();
        while (expected_results.size() != 0) @(posedge i_clk);
        w.index = CFG_COLUMN_COUNT;
        w.wdata = cc_wdata;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        do @(posedge i_clk); while (!cfg_ch.ready);
        column_count_reg = cc_wdata;
        w.index = CFG_BAND_SLOTS;
        w.wdata = bs_wdata;
        cfg_ch.data <= w;
        do @(posedge i_clk); while (!cfg_ch.ready);
        band_slots_reg = bs_wdata[4:0];
        cfg_ch.valid <= 1'b0;
    endtask

    // Random commands aimed mostly at and around each row's window
    task automatic send_random_items(input int count);
        t_cmd_item                    it;
        int                           n;
        int                           pick;
        int                           c;
        int unsigned                  first;
        logic [CMD_BITS-1:0]          cmd;
        logic [ROW_BITS-1:0]          row;
        logic signed [VALUE_BITS-1:0] value;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                cmd = CMD_PUT;
            else if (pick < 70)
                cmd = CMD_ADD;
            else if (pick < 95)
                cmd = CMD_READ;
            else
                cmd = CMD_UNUSED;

            row = ($urandom_range(0, 9) < 6) ? ROW_BITS'($urandom_range(0, 7))
                                             : ROW_BITS'($urandom_range(0, ROWS - 1));

            first = row_first(row);
            pick  = $urandom_range(0, 99);
            if (pick < 12)
                c = $urandom_range(0, 65535);
            else if (pick < 25)
                c = int'(first) - int'($urandom_range(1, 24));
            else
                c = int'(first) + int'($urandom_range(0, band_width() + 4)) - 2;
            if (c < 0)
                c = 0;
            if (c > 65535)
                c = 65535;

            pick = $urandom_range(0, 19);
            if (pick < 2)
                value = '0;
            else if (pick == 2)
                value = VAL_MAX;
            else if (pick == 3)
                value = VAL_MIN;
            else if (pick == 4)
                value = 32'sd1;
            else if (pick == 5)
                value = -32'sd1;
            else if (pick < 10)
                value = $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
            else
                value = $urandom;

            it = cmd_item(cmd, row, c, value);
            send_cmd(it);
        end
    endtask

    // Result sink: picks a new random stall mode each time the current one runs out
    initial begin : result_stall
        int mode;
        int left;
        res_ch.ready <= 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 120);
            end
            left--;
            case (mode)
                0: begin
                    res_ch.ready <= 1'b1;
                end
                1: begin
                    res_ch.ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    res_ch.ready <= (left % 5 == 0);
                end
                default: begin
                    res_ch.ready <= (left % 23 < 2);
                end
            endcase
        end
    end

    // In-order check of each result transaction
    always @(posedge i_clk) begin : result_checker
        t_res_item want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("%0t unexpected result: expected none, actual value %h status %0d",
                             $time, res_ch.data.read_value, res_ch.data.status);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (res_ch.data.read_value !== want.read_value) begin
                    if (mismatches < REPORT_MAX)
                        $display("%0t read_value mismatch: expected %h, actual %h",
                                 $time, want.read_value, res_ch.data.read_value);
                    mismatches++;
                end
                if (res_ch.data.status !== want.status) begin
                    if (mismatches < REPORT_MAX)
                        $display("%0t status mismatch: expected %0d, actual %0d",
                                 $time, want.status, res_ch.data.status);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: saturation, shifts, add on shift, band edges, empty rows
    task automatic test_default_config();
        send_cmd(cmd_item(CMD_READ,   0, 65535, 32'sd0));
        send_cmd(cmd_item(CMD_PUT,    0, 65535, 32'sd0));
        send_cmd(cmd_item(CMD_PUT,    0, 65535, VAL_MAX));
        send_cmd(cmd_item(CMD_ADD,    0, 65535, 32'sd1));
        send_cmd(cmd_item(CMD_PUT,    0, 65530, -32'sd1));
        send_cmd(cmd_item(CMD_READ,   0, 65535, 32'sd0));
        send_cmd(cmd_item(CMD_ADD,    0, 65520, 32'sh0001_2345));
        send_cmd(cmd_item(CMD_READ,   0, 65535, 32'sd0));
        send_cmd(cmd_item(CMD_READ,   0, 65525, 32'sd0));
        // huge gap wipes the whole window
        send_cmd(cmd_item(CMD_PUT,   63,     0, VAL_MIN));
        send_cmd(cmd_item(CMD_PUT,   63,    16, 32'sd7));
        send_cmd(cmd_item(CMD_PUT,   63,    15, VAL_MIN));
        send_cmd(cmd_item(CMD_ADD,   63,    15, -32'sd1));
        send_cmd(cmd_item(CMD_ADD,   63,     0, VAL_MAX));
        send_cmd(cmd_item(CMD_UNUSED, 63,   15, 32'sh5555_AAAA));
        send_cmd(cmd_item(CMD_READ,  63,    16, 32'sd0));
        send_cmd(cmd_item(CMD_READ,  63,     0, 32'sd0));
        send_cmd(cmd_item(CMD_READ,   0,     0, 32'sd0));
        send_cmd(cmd_item(CMD_ADD,    5, 65535, 32'sd0));
        send_cmd(cmd_item(CMD_ADD,    5, 65535, VAL_MIN));
        send_cmd(cmd_item(CMD_READ,   5, 65535, 32'sd0));
        send_cmd(cmd_item(CMD_PUT,    0, 65535, 32'sh0001_0000));
        send_cmd(cmd_item(CMD_UNUSED, 0, 65535, -32'sd1));
    endtask

    // Out-of-range register values clamp; minimum column count
    task automatic test_clamped_registers();
        configure(17'd0, 17'd0);
        send_random_items(60);
        configure(17'h1_FFFF, 17'h1_FFFF);
        send_random_items(60);
        configure(17'd1, 17'(BAND_MAX));
        send_random_items(60);
    endtask

    // Narrow band: most stores fall outside or shift
    task automatic test_narrow_band();
        configure(17'd24, 17'd3);
        send_random_items(100);
    endtask

    // Shrink then widen the band; upper slots keep stale contents
    task automatic test_band_resize();
        logic [CC_BITS-1:0] bs;
        configure(17'd40, 17'(BAND_MAX));
        send_random_items(100);
        bs = CC_BITS'($urandom);
        bs[4:0] = 5'd5;
        configure(17'd40, bs);
        send_random_items(80);
        configure(17'd40, 17'(BAND_MAX));
        send_random_items(80);
    endtask

    // Random register settings
    task automatic test_random_configs();
        logic [CC_BITS-1:0] cc;
        logic [CC_BITS-1:0] bs;
        int                 round;
        for (round = 0; round < 4; round++) begin
            cc = (round == 0) ? CC_BITS'($urandom) : CC_BITS'($urandom_range(1, 300));
            bs = CC_BITS'($urandom);
            bs[4:0] = 5'($urandom_range(0, 31));
            configure(cc, bs);
            send_random_items(60);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        mismatches       = 0;
        burst_left       = 0;
        column_count_reg = CC_MAX;
        band_slots_reg   = 5'(BAND_MAX);
        foreach (band_mem[r, k])
            band_mem[r][k] = '0;
        foreach (first_col[r]) begin
            first_col[r] = '0;
            row_used[r]  = 1'b0;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_config();
        test_clamped_registers();
        test_narrow_band();
        test_band_resize();
        test_random_configs();

        hold_commands();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("banded_row_store_insert_unit test passed");
        else
            $display("banded_row_store_insert_unit test failed");
        $finish;
    end

endmodule
